>>> rtl/rcw_pkg.sv
package rcw_pkg;

  localparam int TEX_SLOTS        = 4;
  localparam int TEX_WIDTH        = 64;
  localparam int TEX_HEIGHT       = 64;
  localparam int MAX_FRAME_HEIGHT = 1024;

  localparam int HF_W    = 11;
  localparam int D_W     = 16;
  localparam int SIZE_W  = HF_W + 8;
  localparam int PROD_W  = SIZE_W + D_W;
  localparam int TROW_W  = $clog2(TEX_HEIGHT);
  localparam int TCOL_W  = $clog2(TEX_WIDTH);
  localparam int SLOT_W  = 2;
  localparam int IDX_W   = 12;
  localparam int WORDS_W = TROW_W + TCOL_W;
  localparam int ADDR_W  = SLOT_W + WORDS_W;
  localparam int DEN_W   = HF_W + 2;
  localparam int SDEN_W  = D_W + 1;
  localparam int TEX_WORDS = TEX_WIDTH * TEX_HEIGHT;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef struct packed {
    logic                    vld;
    logic                    typ;
    logic [SLOT_W-1:0]       slot;
    logic [IDX_W-1:0]        tidx;
    logic [31:0]             tval;
    logic [9:0]              col;
    logic [9:0]              row;
    logic [D_W-1:0]          ray_d;
    logic [15:0]             u;
    logic [SIZE_W-1:0]       num;
    logic [SIZE_W-1:0]       quo;
    logic [D_W-1:0]          rem;
    logic                    on;
    logic [SIZE_W-1:0]       v;
    logic [PROD_W-1:0]       prod;
    logic                    sat;
    logic [DEN_W-1:0]        rrem;
    logic [TROW_W-1:0]       rnum;
    logic [TROW_W-1:0]       rquo;
    logic [ADDR_W-1:0]       addr;
    logic [2:0][SDEN_W-1:0]  srem;
    logic [2:0][7:0]         squo;
    logic [31:0]             texel;
  } pipe_t;

  // one restoring step of wall size = hf*256 / distance
  function automatic pipe_t size_step(pipe_t p);
    pipe_t        n;
    logic [D_W:0] r;
    n = p;
    r = {p.rem, p.num[SIZE_W-1]};
    n.num = p.num << 1;
    if (r >= {1'b0, p.ray_d}) begin
      n.rem = D_W'(r - {1'b0, p.ray_d});
      n.quo = {p.quo[SIZE_W-2:0], 1'b1};
    end else begin
      n.rem = r[D_W-1:0];
      n.quo = {p.quo[SIZE_W-2:0], 1'b0};
    end
    return n;
  endfunction

  // one restoring step of texture row = v*distance / (4*hf)
  function automatic pipe_t row_step(pipe_t p, logic [HF_W-1:0] hf);
    pipe_t          n;
    logic [DEN_W:0] r;
    logic [DEN_W:0] den;
    n = p;
    den = {1'b0, hf, 2'b00};
    r = {p.rrem, p.rnum[TROW_W-1]};
    n.rnum = p.rnum << 1;
    if (r >= den) begin
      n.rrem = DEN_W'(r - den);
      n.rquo = {p.rquo[TROW_W-2:0], 1'b1};
    end else begin
      n.rrem = r[DEN_W-1:0];
      n.rquo = {p.rquo[TROW_W-2:0], 1'b0};
    end
    return n;
  endfunction

  // one restoring step of channel*512 / (distance+512) on all three channels
  function automatic pipe_t shade_step(pipe_t p);
    pipe_t           n;
    logic [SDEN_W:0] r;
    logic [SDEN_W:0] den;
    n = p;
    den = {1'b0, {1'b0, p.ray_d} + SDEN_W'(512)};
    for (int c = 0; c < 3; c++) begin
      r = {p.srem[c], 1'b0};
      if (r >= den) begin
        n.srem[c] = SDEN_W'(r - den);
        n.squo[c] = {p.squo[c][6:0], 1'b1};
      end else begin
        n.srem[c] = r[SDEN_W-1:0];
        n.squo[c] = {p.squo[c][6:0], 1'b0};
      end
    end
    return n;
  endfunction

endpackage

>>> rtl/raycast_wall_column_texel_shader_unit.sv
// channel   | handshake               | payload
// request   | in_valid_i / in_stall_o  | req_type_i .. tex_u_i
// result    | out_valid_o / out_stall_i| write_pixel_o .. pixel_color_o
// config    | cfg_we_i                 | cfg_data_i (frame_height)
//
// One request enters per cycle while in_stall_o is low.
// The path runs through the 19-stage wall-size divider, the 6-stage row divider
// and the 8-stage channel divider, plus the texture memory read port.
// Reset clears all valid bits; the texture store is not cleared.
// The whole pipeline holds while a result waits and out_stall_i is high.
module raycast_wall_column_texel_shader_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [1:0]                  texture_slot_i,
  input  logic [11:0]                 texel_index_i,
  input  logic [31:0]                 texel_value_i,
  input  logic [9:0]                  screen_column_i,
  input  logic [9:0]                  screen_row_i,
  input  logic [15:0]                 distance_i,
  input  logic [15:0]                 tex_u_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        write_pixel_o,
  output logic [9:0]                  out_column_o,
  output logic [9:0]                  out_row_o,
  output logic [31:0]                 pixel_color_o,
  input  logic                        cfg_we_i,
  input  logic [10:0]                 cfg_data_i
);

  logic [rcw_pkg::HF_W-1:0] hf_q;
  logic                     en;
  rcw_pkg::pipe_t           in_req, sz_req, rm_req, tm_req, sh_req;
  logic                     out_vld_q, wr_q;
  logic [9:0]               col_q, row_q;
  logic [31:0]              color_q;
  logic [31:0]              color_d;

  // hold effective frame height, clamped to the maximum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hf_q <= rcw_pkg::HF_W'(240);
    end else if (cfg_we_i) begin
      hf_q <= (cfg_data_i > rcw_pkg::HF_W'(rcw_pkg::MAX_FRAME_HEIGHT)) ?
              rcw_pkg::HF_W'(rcw_pkg::MAX_FRAME_HEIGHT) : cfg_data_i;
    end
  end

  assign en = !out_vld_q || !out_stall_i;
  assign in_stall_o = !en;

  always_comb begin
    in_req = '0;
    in_req.vld   = in_valid_i;
    in_req.typ   = req_type_i;
    in_req.slot  = texture_slot_i;
    in_req.tidx  = texel_index_i;
    in_req.tval  = texel_value_i;
    in_req.col   = screen_column_i;
    in_req.row   = screen_row_i;
    in_req.ray_d = distance_i;
    in_req.u     = tex_u_i;
  end

  rcw_size_div u_size (.clk_i, .rst_ni, .en_i(en), .hf_i(hf_q), .req_i(in_req), .req_o(sz_req));
  rcw_row_map  u_row  (.clk_i, .rst_ni, .en_i(en), .hf_i(hf_q), .req_i(sz_req), .req_o(rm_req));
  rcw_tex_mem  u_mem  (.clk_i, .rst_ni, .en_i(en), .req_i(rm_req), .req_o(tm_req));
  rcw_shade    u_shd  (.clk_i, .rst_ni, .en_i(en), .req_i(tm_req), .req_o(sh_req));

  assign color_d = {sh_req.texel[31:24], sh_req.squo[2], sh_req.squo[1], sh_req.squo[0]};

  // output register: drop payload to zero when nothing is written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      wr_q      <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
      color_q   <= '0;
    end else if (en) begin
      out_vld_q <= sh_req.vld;
      wr_q      <= sh_req.on;
      col_q     <= sh_req.on ? sh_req.col : '0;
      row_q     <= sh_req.on ? sh_req.row : '0;
      color_q   <= sh_req.on ? color_d : '0;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign write_pixel_o = wr_q;
  assign out_column_o  = col_q;
  assign out_row_o     = row_q;
  assign pixel_color_o = color_q;

endmodule

>>> rtl/rcw_size_div.sv
module rcw_size_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [rcw_pkg::HF_W-1:0]    hf_i,
  input  rcw_pkg::pipe_t              req_i,
  output rcw_pkg::pipe_t              req_o
);

  localparam int STEPS = rcw_pkg::SIZE_W;

  rcw_pkg::pipe_t st_q [STEPS+1];
  rcw_pkg::pipe_t cap_d;

  // seed the divider with hf*256
  always_comb begin
    cap_d = req_i;
    cap_d.num = {hf_i, 8'b0};
    cap_d.rem = '0;
    cap_d.quo = '0;
  end

  // advance one quotient bit per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= STEPS; s++) st_q[s] <= '0;
    end else if (en_i) begin
      st_q[0] <= cap_d;
      for (int s = 0; s < STEPS; s++) st_q[s+1] <= rcw_pkg::size_step(st_q[s]);
    end
  end

  assign req_o = st_q[STEPS];

endmodule

>>> rtl/rcw_row_map.sv
module rcw_row_map (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [rcw_pkg::HF_W-1:0]    hf_i,
  input  rcw_pkg::pipe_t              req_i,
  output rcw_pkg::pipe_t              req_o
);

  localparam int STEPS = rcw_pkg::TROW_W;

  rcw_pkg::pipe_t a_q, b_q, c_q, adr_q;
  rcw_pkg::pipe_t a_d, b_d, c_d, adr_d;
  rcw_pkg::pipe_t dv_q [STEPS+1];

  logic [rcw_pkg::SIZE_W-1:0] hf_w, start, i_w;
  logic [rcw_pkg::SLOT_W:0]   slot_w;

  assign hf_w = rcw_pkg::SIZE_W'(hf_i);

  // center the wall and decide whether the row is on it
  always_comb begin
    a_d = req_i;
    start = (req_i.quo <= hf_w) ? ((hf_w - req_i.quo) >> 1) : '0;
    i_w = rcw_pkg::SIZE_W'(req_i.row) - start;
    a_d.on = (req_i.typ == rcw_pkg::REQ_DRAW) && (req_i.ray_d != '0) && (hf_i != '0) &&
             (rcw_pkg::SIZE_W'(req_i.row) >= start) && (i_w < req_i.quo) && (i_w < hf_w);
    a_d.v = i_w + ((req_i.quo > hf_w) ? ((req_i.quo - hf_w) >> 1) : '0);
  end

  // multiply v by distance
  always_comb begin
    b_d = a_q;
    b_d.prod = rcw_pkg::PROD_W'(a_q.v) * rcw_pkg::PROD_W'(a_q.ray_d);
  end

  // flag saturation and seed the row divider
  always_comb begin
    c_d = b_q;
    c_d.sat = b_q.prod >= rcw_pkg::PROD_W'({hf_i, 8'b0});
    c_d.rrem = b_q.prod[rcw_pkg::TROW_W +: rcw_pkg::DEN_W];
    c_d.rnum = b_q.prod[rcw_pkg::TROW_W-1:0];
    c_d.rquo = '0;
  end

  // form the store address
  always_comb begin
    adr_d = dv_q[STEPS];
    slot_w = {1'b0, dv_q[STEPS].slot};
    if (dv_q[STEPS].typ == rcw_pkg::REQ_LOAD) begin
      adr_d.addr = {dv_q[STEPS].slot, dv_q[STEPS].tidx[rcw_pkg::WORDS_W-1:0]};
    end else begin
      adr_d.addr = {(slot_w < (rcw_pkg::SLOT_W+1)'(rcw_pkg::TEX_SLOTS)) ?
                      dv_q[STEPS].slot : rcw_pkg::SLOT_W'(0),
                    dv_q[STEPS].sat ? {rcw_pkg::TROW_W{1'b1}} : dv_q[STEPS].rquo,
                    dv_q[STEPS].u[15 -: rcw_pkg::TCOL_W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      adr_q <= '0;
      for (int s = 0; s <= STEPS; s++) dv_q[s] <= '0;
    end else if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
      dv_q[0] <= c_d;
      for (int s = 0; s < STEPS; s++) dv_q[s+1] <= rcw_pkg::row_step(dv_q[s], hf_i);
      adr_q <= adr_d;
    end
  end

  assign req_o = adr_q;

endmodule

>>> rtl/rcw_tex_mem.sv
module rcw_tex_mem (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rcw_pkg::pipe_t  req_i,
  output rcw_pkg::pipe_t  req_o
);

  localparam int DEPTH = rcw_pkg::TEX_SLOTS * rcw_pkg::TEX_WORDS;

  logic [31:0]    mem [DEPTH];
  logic [31:0]    rd_q;
  rcw_pkg::pipe_t p_q;
  logic           wr_ok;

  assign wr_ok = req_i.vld && (req_i.typ == rcw_pkg::REQ_LOAD) &&
                 ({1'b0, req_i.slot} < (rcw_pkg::SLOT_W+1)'(rcw_pkg::TEX_SLOTS)) &&
                 ({1'b0, req_i.tidx} < (rcw_pkg::IDX_W+1)'(rcw_pkg::TEX_WORDS));

  // write loads, read texels for draws, in request order
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (wr_ok) mem[req_i.addr] <= req_i.tval;
      rd_q <= mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else if (en_i) begin
      p_q <= req_i;
    end
  end

  always_comb begin
    req_o = p_q;
    req_o.texel = rd_q;
  end

endmodule

>>> rtl/rcw_shade.sv
module rcw_shade (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rcw_pkg::pipe_t  req_i,
  output rcw_pkg::pipe_t  req_o
);

  localparam int STEPS = 8;

  rcw_pkg::pipe_t sh_q [STEPS+1];
  rcw_pkg::pipe_t seed_d;

  // seed each channel remainder with channel*2 (numerator shifted right by 8)
  always_comb begin
    seed_d = req_i;
    for (int c = 0; c < 3; c++) begin
      seed_d.srem[c] = rcw_pkg::SDEN_W'({req_i.texel[8*c +: 8], 1'b0});
      seed_d.squo[c] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= STEPS; s++) sh_q[s] <= '0;
    end else if (en_i) begin
      sh_q[0] <= seed_d;
      for (int s = 0; s < STEPS; s++) sh_q[s+1] <= rcw_pkg::shade_step(sh_q[s]);
    end
  end

  assign req_o = sh_q[STEPS];

endmodule

>>> rtl/rcw_checker.sv
module rcw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        write_pixel_o,
  input logic [9:0]  out_column_o,
  input logic [9:0]  out_row_o,
  input logic [31:0] pixel_color_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_color_o))
    else $error("stalled result changed");

  // an unwritten result carries zeros
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_pixel_o |->
      (pixel_color_o == 32'd0) && (out_column_o == 10'd0) && (out_row_o == 10'd0))
    else $error("unwritten result not zero");

  // requests are taken whenever the output slot is free
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // stall on input follows a waiting result only
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("spurious input stall");

endmodule

bind raycast_wall_column_texel_shader_unit rcw_checker u_rcw_checker (.*);

>>> tb/raycast_wall_column_texel_shader_unit_test.sv
module raycast_wall_column_texel_shader_unit_test;

  typedef struct {
    logic        write_pixel;
    logic [9:0]  column;
    logic [9:0]  row;
    logic [31:0] color;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = rcw_pkg::REQ_LOAD;
  logic [1:0]  texture_slot_i = '0;
  logic [11:0] texel_index_i = '0;
  logic [31:0] texel_value_i = '0;
  logic [9:0]  screen_column_i = '0;
  logic [9:0]  screen_row_i = '0;
  logic [15:0] distance_i = '0;
  logic [15:0] tex_u_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        write_pixel_o;
  logic [9:0]  out_column_o;
  logic [9:0]  out_row_o;
  logic [31:0] pixel_color_o;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_data_i = '0;

  // shadow state of the block
  logic [31:0] texel_mem [rcw_pkg::TEX_SLOTS*rcw_pkg::TEX_WORDS];
  bit          texel_written [rcw_pkg::TEX_SLOTS*rcw_pkg::TEX_WORDS];
  logic [10:0] frame_height = 11'd240;

  pixel_t expected_pixels [$];
  int     errors = 0;
  int     burst_left = 0;
  bit     hold_go = 1'b0;
  bit     hold_seen = 1'b0;
  int     hold_left = 0;
  int     rx_cycle = 0;

  raycast_wall_column_texel_shader_unit dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  // texel address a draw samples, or -1 when the pixel is off the wall
  function automatic int texel_address(logic [1:0] slot, logic [9:0] row,
                                       logic [15:0] ray_d, logic [15:0] u);
    longint unsigned hf, size, start, i, v, trow, tcol;
    hf = (frame_height > 11'(rcw_pkg::MAX_FRAME_HEIGHT)) ?
         64'(rcw_pkg::MAX_FRAME_HEIGHT) : 64'(frame_height);
    if (ray_d == 0 || hf == 0) return -1;
    size = (hf * 256) / 64'(ray_d);
    start = (size <= hf) ? ((hf - size) >> 1) : 0;
    if (64'(row) < start) return -1;
    i = 64'(row) - start;
    if (i >= size || i >= hf) return -1;
    v = i + ((size > hf) ? ((size - hf) >> 1) : 0);
    trow = (v * 64'(ray_d) * rcw_pkg::TEX_HEIGHT) / (hf * 256);
    if (trow > rcw_pkg::TEX_HEIGHT - 1) trow = rcw_pkg::TEX_HEIGHT - 1;
    tcol = (64'(u) * rcw_pkg::TEX_WIDTH) >> 16;
    return int'(slot) * rcw_pkg::TEX_WORDS + int'(trow) * rcw_pkg::TEX_WIDTH + int'(tcol);
  endfunction

  // divide r, g and b by distance/512+1, keep alpha
  function automatic logic [31:0] dim_texel(logic [31:0] texel, logic [15:0] ray_d);
    logic [31:0] c;
    longint unsigned ch;
    c = {texel[31:24], 24'h0};
    for (int k = 0; k < 3; k++) begin
      ch = 64'(texel[8*k +: 8]);
      ch = (ch * 512) / (64'(ray_d) + 512);
      c[8*k +: 8] = ch[7:0];
    end
    return c;
  endfunction

  // offer one request, predict its result once taken
  task automatic send_request(logic typ, logic [1:0] slot, logic [11:0] idx,
                              logic [31:0] val, logic [9:0] col, logic [9:0] row,
                              logic [15:0] ray_d, logic [15:0] u);
    pixel_t px;
    int     addr;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    req_type_i <= typ;
    texture_slot_i <= slot;
    texel_index_i <= idx;
    texel_value_i <= val;
    screen_column_i <= col;
    screen_row_i <= row;
    distance_i <= ray_d;
    tex_u_i <= u;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    px = '{1'b0, 10'd0, 10'd0, 32'd0};
    if (typ == rcw_pkg::REQ_LOAD) begin
      texel_mem[int'(slot) * rcw_pkg::TEX_WORDS + int'(idx)] = val;
      texel_written[int'(slot) * rcw_pkg::TEX_WORDS + int'(idx)] = 1'b1;
    end else begin
      addr = texel_address(slot, row, ray_d, u);
      if (addr >= 0) px = '{1'b1, col, row, dim_texel(texel_mem[addr], ray_d)};
    end
    expected_pixels.push_back(px);
  endtask

  task automatic load_texel(logic [1:0] slot, logic [11:0] idx, logic [31:0] val);
    send_request(rcw_pkg::REQ_LOAD, slot, idx, val, 10'($urandom), 10'($urandom),
                 16'($urandom), 16'($urandom));
  endtask

  // draw one pixel, loading its texel first if it was never written
  task automatic shade_pixel(logic [1:0] slot, logic [9:0] col, logic [9:0] row,
                             logic [15:0] ray_d, logic [15:0] u);
    int addr;
    addr = texel_address(slot, row, ray_d, u);
    if (addr >= 0 && !texel_written[addr])
      load_texel(2'(addr / rcw_pkg::TEX_WORDS), 12'(addr % rcw_pkg::TEX_WORDS), $urandom);
    send_request(rcw_pkg::REQ_DRAW, slot, 12'($urandom), $urandom, col, row, ray_d, u);
  endtask

  // stop offering and wait for every pending result to come back
  task automatic drain;
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_frame_height(logic [10:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    frame_height = value;
  endtask

  task automatic random_pixels(int count);
    int hf;
    logic [15:0] ray_d;
    logic [9:0] row;
    hf = (int'(frame_height) > rcw_pkg::MAX_FRAME_HEIGHT) ? rcw_pkg::MAX_FRAME_HEIGHT
                                                         : int'(frame_height);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        load_texel(2'($urandom), 12'($urandom), $urandom);
      end else begin
        ray_d = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1200));
        row = ($urandom_range(0, 9) < 7 && hf > 0) ? 10'($urandom_range(0, hf - 1))
                                                    : 10'($urandom);
        shade_pixel(2'($urandom), 10'($urandom), row, ray_d, 16'($urandom));
      end
    end
  endtask

  task automatic test_directed;
    load_texel(2'd0, 12'd0, 32'hFFFF_FFFF);
    load_texel(2'd3, 12'd4095, 32'h0000_0000);
    load_texel(2'd3, 12'd4095, 32'hA5C3_7E81);
    shade_pixel(2'd0, 10'd5, 10'd120, 16'd0, 16'd0);
    shade_pixel(2'd0, 10'd0, 10'd0, 16'd256, 16'd0);
    shade_pixel(2'd3, 10'd1023, 10'd239, 16'd256, 16'hFFFF);
    shade_pixel(2'd1, 10'd7, 10'd240, 16'd256, 16'h8000);
    shade_pixel(2'd2, 10'd9, 10'd1023, 16'd1, 16'h1234);
    shade_pixel(2'd2, 10'd9, 10'd0, 16'd1, 16'hFFFF);
    shade_pixel(2'd0, 10'd9, 10'd120, 16'hFFFF, 16'h0);
    shade_pixel(2'd0, 10'd9, 10'd119, 16'hFFFF, 16'h0);
    shade_pixel(2'd1, 10'd3, 10'd10, 16'd1024, 16'h4000);
    shade_pixel(2'd1, 10'd3, 10'd100, 16'd1024, 16'h4000);
    shade_pixel(2'd3, 10'd512, 10'd200, 16'd128, 16'hC000);
  endtask

  task automatic test_frame_heights;
    set_frame_height(11'd0);
    random_pixels(40);
    set_frame_height(11'd1);
    random_pixels(60);
    shade_pixel(2'd0, 10'd1, 10'd0, 16'd256, 16'd0);
    set_frame_height(11'd1024);
    random_pixels(300);
    set_frame_height(11'd2047);
    random_pixels(250);
    set_frame_height(11'd13);
    random_pixels(150);
    set_frame_height(11'd240);
    random_pixels(250);
  endtask

  // hold the receiver off while requests keep coming, then pause for a drain
  task automatic test_backpressure;
    burst_left = 1000;
    hold_go = 1'b1;
    random_pixels(100);
    drain();
    random_pixels(130);
  endtask

  // result check
  always @(posedge clk_i) begin
    pixel_t exp_px;
    if (out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $error("result with nothing pending");
        errors++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (write_pixel_o !== exp_px.write_pixel) begin
          $error("write_pixel exp %0d got %0d", exp_px.write_pixel, write_pixel_o);
          errors++;
        end
        if (out_column_o !== exp_px.column) begin
          $error("out_column exp %0d got %0d", exp_px.column, out_column_o);
          errors++;
        end
        if (out_row_o !== exp_px.row) begin
          $error("out_row exp %0d got %0d", exp_px.row, out_row_o);
          errors++;
        end
        if (pixel_color_o !== exp_px.color) begin
          $error("pixel_color exp %h got %h", exp_px.color, pixel_color_o);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold when asked
  always @(posedge clk_i) begin
    if (hold_go && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = 400;
    end
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < ((((rx_cycle / 200) % 3) == 0) ? 0 : 45));
    end
  end

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    test_directed();
    test_frame_heights();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
